>>> design/mrpt_pkg.sv
package mrpt_pkg;
	localparam int unsigned W = 64;
	localparam logic [W-1:0] LIMIT_THREE = 64'd4759123140;
	localparam logic [W-1:0] LIMIT_SIX = 64'd3474749660382;
	localparam int unsigned NB = 7;

	typedef logic [W-1:0] word_t;

	// base table: row 0 small set, row 1 mid set, row 2 large set
	function automatic word_t base_of(input logic [1:0] set, input logic [2:0] idx);
		word_t r;
		r = '0;
		unique case (set)
			2'd0: begin
				unique case (idx)
					3'd0: r = 64'd2;
					3'd1: r = 64'd7;
					3'd2: r = 64'd61;
					default: r = '0;
				endcase
			end
			2'd1: begin
				unique case (idx)
					3'd0: r = 64'd2;
					3'd1: r = 64'd3;
					3'd2: r = 64'd5;
					3'd3: r = 64'd7;
					3'd4: r = 64'd11;
					3'd5: r = 64'd13;
					default: r = '0;
				endcase
			end
			default: begin
				unique case (idx)
					3'd0: r = 64'd2;
					3'd1: r = 64'd325;
					3'd2: r = 64'd9375;
					3'd3: r = 64'd28178;
					3'd4: r = 64'd450775;
					3'd5: r = 64'd9780504;
					3'd6: r = 64'd1795265022;
					default: r = '0;
				endcase
			end
		endcase
		return r;
	endfunction

	function automatic logic [2:0] base_count(input logic [1:0] set);
		logic [2:0] c;
		unique case (set)
			2'd0: c = 3'd3;
			2'd1: c = 3'd6;
			default: c = 3'd7;
		endcase
		return c;
	endfunction

	typedef struct packed {
		logic start;
		logic mod_only;
	} mm_ctrl_t;
endpackage

>>> design/mrpt_mulmod.sv
// Bit-serial modular multiply: one bit of b per cycle.
// mod_only: computes a mod m (a may be >= m) by restoring subtraction.
module mrpt_mulmod (
	input  logic             clk,
	input  logic             arst_n,
	input  mrpt_pkg::mm_ctrl_t ctrl,
	input  mrpt_pkg::word_t  a,
	input  mrpt_pkg::word_t  b,
	input  mrpt_pkg::word_t  m,
	output logic             done,
	output mrpt_pkg::word_t  r
);
	import mrpt_pkg::*;

	word_t a_q, b_q, m_q, r_q;
	logic [6:0] cnt_q;
	logic busy_q, mod_q;
	word_t dbl, sum;
	logic [W:0] t2, t3;

	always_comb begin
		t2 = {r_q, 1'b0};
		dbl = (t2 >= {1'b0, m_q}) ? W'(t2 - {1'b0, m_q}) : t2[W-1:0];
		if (mod_q) begin
			// shift in next bit of dividend
			t3 = {r_q, b_q[W-1]};
			sum = (t3 >= {1'b0, m_q}) ? W'(t3 - {1'b0, m_q}) : t3[W-1:0];
		end else begin
			t3 = {1'b0, dbl} + {1'b0, a_q};
			sum = b_q[W-1] ? ((t3 >= {1'b0, m_q}) ? W'(t3 - {1'b0, m_q}) : t3[W-1:0])
			               : dbl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
			mod_q <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'(W);
				mod_q <= ctrl.mod_only;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			a_q <= a;
			b_q <= ctrl.mod_only ? a : b;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= sum;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	assign r = r_q;
endmodule

>>> design/miller_rabin_prime_test.sv
// Deterministic Miller-Rabin primality test, 64-bit.
// Input channel s_axis: one beat carries one number (tdata[63:0]).
// Output channel m_axis: one beat carries is_prime in tdata[0] (tdata[7:1] zero).
// One number is processed at a time. Every modular product runs through a
// single bit-serial multiplier in 64 bit steps. A round reduces its base,
// then runs up to two products per bit of d and one per squaring; the bits
// of d and the squarings share the 63 bits below the top of n, and an item
// runs at most seven rounds.
// Trivial inputs (below 2, even) offer the result beat the cycle after the
// number is taken; the next number can be taken the cycle after the result beat.
// The result sits in an output register; s_axis_tready returns once the
// result beat is taken, so a stalled receiver simply holds the block.
// Reset (arst_n low) drops any item in flight and clears m_axis_tvalid.
module miller_rabin_prime_test (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [63:0] number
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] is_prime, [7:1] zero
);
	import mrpt_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_BASE  = 9'b000000010,
		S_RED   = 9'b000000100,
		S_PSTEP = 9'b000001000,
		S_PWAIT = 9'b000010000,
		S_CHK   = 9'b000100000,
		S_SQW   = 9'b001000000,
		S_NEXT  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	state_t st_q;
	word_t n_q, d_q, e_q, acc_q, bs_q, x_q;
	logic [5:0] s_q, k_q;
	logic [1:0] set_q;
	logic [2:0] idx_q;
	logic phase_q; // 0: acc*base, 1: base*base
	logic res_q;
	mm_ctrl_t mc;
	word_t ma, mb;
	logic mdone;
	word_t mr;
	word_t nm1;

	assign nm1 = n_q - 64'd1;

	mrpt_mulmod u_mm (.clk(clk), .arst_n(arst_n), .ctrl(mc), .a(ma), .b(mb), .m(n_q),
		.done(mdone), .r(mr));

	assign s_axis_tready = st_q == S_IDLE;
	assign m_axis_tvalid = st_q == S_OUT;
	assign m_axis_tdata = {7'd0, res_q};

	always_comb begin
		mc = '0;
		ma = acc_q;
		mb = bs_q;
		unique case (st_q)
			S_BASE: begin
				mc.start = 1'b1;
				mc.mod_only = 1'b1;
				ma = base_of(set_q, idx_q);
			end
			S_PSTEP: begin
				mc.start = (e_q != '0);
				ma = phase_q ? bs_q : acc_q;
			end
			S_CHK: begin
				mc.start = 1'b1;
				ma = x_q;
				mb = x_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			res_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: if (s_axis_tvalid) begin
					n_q <= s_axis_tdata;
					idx_q <= '0;
					phase_q <= 1'b0;
					if (s_axis_tdata < 64'd2 || !s_axis_tdata[0]) begin
						res_q <= s_axis_tdata == 64'd2;
						st_q <= S_OUT;
					end else begin
						// n-1 = d*2^s; d shifts one bit per cycle in S_BASE, S_RED and S_PSTEP while even
						d_q <= s_axis_tdata - 64'd1;
						s_q <= '0;
						set_q <= (s_axis_tdata > LIMIT_SIX) ? 2'd2 :
						         (s_axis_tdata > LIMIT_THREE) ? 2'd1 : 2'd0;
						res_q <= 1'b1;
						st_q <= S_BASE;
					end
				end
				S_BASE: begin
					if (!d_q[0]) begin
						d_q <= {1'b0, d_q[W-1:1]};
						s_q <= s_q + 6'd1;
					end
					st_q <= S_RED;
				end
				S_RED: begin
					if (!d_q[0]) begin
						d_q <= {1'b0, d_q[W-1:1]};
						s_q <= s_q + 6'd1;
					end
					if (mdone) begin
						if (mr == '0) st_q <= S_NEXT;
						else begin
							bs_q <= mr;
							acc_q <= 64'd1;
							e_q <= d_q;
							phase_q <= 1'b0;
							st_q <= S_PSTEP;
						end
					end
				end
				S_PSTEP: begin
					if (!d_q[0]) begin
						d_q <= {1'b0, d_q[W-1:1]};
						s_q <= s_q + 6'd1;
					end
					if (e_q == '0) begin
						x_q <= acc_q;
						k_q <= 6'd1;
						if (acc_q == 64'd1 || acc_q == nm1) st_q <= S_NEXT;
						else if (s_q <= 6'd1) begin
							res_q <= 1'b0;
							st_q <= S_OUT;
						end else st_q <= S_CHK;
					end else if (!phase_q && !e_q[0]) begin
						phase_q <= 1'b1;
					end else st_q <= S_PWAIT;
				end
				S_PWAIT: if (mdone) begin
					if (!phase_q) acc_q <= mr;
					else begin
						bs_q <= mr;
						e_q <= {1'b0, e_q[W-1:1]};
					end
					phase_q <= !phase_q;
					st_q <= S_PSTEP;
				end
				S_CHK: st_q <= S_SQW;
				S_SQW: if (mdone) begin
					x_q <= mr;
					k_q <= k_q + 6'd1;
					if (mr == nm1) st_q <= S_NEXT;
					else if (k_q + 6'd1 >= s_q) begin
						res_q <= 1'b0;
						st_q <= S_OUT;
					end else st_q <= S_CHK;
				end
				S_NEXT: begin
					if (idx_q + 3'd1 >= base_count(set_q)) st_q <= S_OUT;
					else begin
						idx_q <= idx_q + 3'd1;
						st_q <= S_BASE;
					end
				end
				S_OUT: if (m_axis_tready) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> design/mrpt_checker.sv
module mrpt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_axis_tvalid,
	input logic       s_axis_tready,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
		else $error("pad bits set");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input open while result pending");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item taken");
endmodule

bind miller_rabin_prime_test mrpt_checker u_chk (.*);

>>> verif/tb_miller_rabin_prime_test.sv
`timescale 1ns / 100ps

module tb_miller_rabin_prime_test;
	import mrpt_pkg::*;

	// Watchdog, sized well above the slowest correct run: about 100 numbers,
	// and every one of them taken as a worst case (seven rounds per number),
	// plus stalls and gaps.
	localparam int unsigned CYCLE_LIMIT = 40_000_000;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned RAND_PER_PHASE = 20;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;   // [63:0] number
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;   // [0] is_prime, [7:1] zero

	int unsigned cycles;
	int unsigned errors;
	int unsigned snd_idle_pct;
	int unsigned rcv_stall_pct;
	logic        verdict_q[$];   // expected is_prime, oldest first

	miller_rabin_prime_test dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ---------------------------------------------------------------------
	// Primality predictor: exact 128-bit products, reduced mod n.
	// ---------------------------------------------------------------------
	function automatic word_t mul_reduce(input word_t a, input word_t b, input word_t m);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return word_t'(p % {64'd0, m});
	endfunction

	function automatic word_t exp_reduce(input word_t b, input word_t e, input word_t m);
		word_t acc;
		word_t sq;
		word_t k;
		acc = 64'd1;
		sq = b;
		k = e;
		while (k != 0) begin
			if (k[0])
				acc = mul_reduce(acc, sq, m);
			sq = mul_reduce(sq, sq, m);
			k = k >> 1;
		end
		return acc;
	endfunction

	// strong probable-prime round for witness a
	function automatic logic witness_passes(input word_t n, input word_t d, input int s,
			input word_t a);
		word_t x;
		x = exp_reduce(a, d, n);
		if (x == 1 || x == n - 1)
			return 1'b1;
		for (int k = 1; k < s; k++) begin
			x = mul_reduce(x, x, n);
			if (x == n - 1)
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic prime_verdict(input word_t n);
		word_t witnesses[$];
		word_t d;
		word_t a;
		int s;
		if (n < 2)
			return 1'b0;
		if (!n[0])
			return n == 2;
		d = n - 1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		if (n > LIMIT_SIX)
			witnesses = '{2, 325, 9375, 28178, 450775, 9780504, 1795265022};
		else if (n > LIMIT_THREE)
			witnesses = '{2, 3, 5, 7, 11, 13};
		else
			witnesses = '{2, 7, 61};
		foreach (witnesses[i]) begin
			a = witnesses[i] % n;
			// witness that is a multiple of n says nothing; skip it
			if (a != 0 && !witness_passes(n, d, s, a))
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------
	// Sender: one beat per call; valid stays up between back-to-back beats.
	// ---------------------------------------------------------------------
	task automatic send_number(input word_t n, input logic pinned, input logic verdict);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= n;
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (pinned && verdict != prime_verdict(n))
			$error("table entry for %0d disagrees with predictor", n);
		verdict_q.push_back(pinned ? verdict : prime_verdict(n));
	endtask

	// Mostly small odd numbers keep the exponentiations short; a few span
	// the mid and full 64-bit ranges so every input bit toggles.
	function automatic word_t pick_number();
		word_t n;
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			n = word_t'($urandom_range(65535, 3));
		else if (r < 80)
			n = {32'd0, $urandom};
		else if (r < 92)
			n = LIMIT_THREE + ({$urandom, $urandom} % (LIMIT_SIX - LIMIT_THREE));
		else
			n = {$urandom, $urandom};
		if ($urandom_range(9) != 0)
			n[0] = 1'b1;  // odd numbers reach the rounds; evens are noise
		return n;
	endfunction

	// Result checker and receiver backpressure
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (verdict_q.size() == 0) begin
				$error("is_prime: unexpected beat, actual %0b", m_axis_tdata[0]);
				errors++;
			end else begin
				logic want;
				want = verdict_q.pop_front();
				if (m_axis_tdata[0] !== want) begin
					$error("is_prime: expected %0b, actual %0b", want, m_axis_tdata[0]);
					errors++;
				end
			end
		end
		m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Directed table; pinned rows carry a verdict readable at a glance
	typedef struct {
		word_t n;
		logic  pinned;
		logic  verdict;
	} probe_t;

	probe_t probes[] = '{
		'{64'd0, 1'b1, 1'b0},                      // zero
		'{64'd1, 1'b1, 1'b0},                      // one
		'{64'd2, 1'b1, 1'b1},                      // only even prime
		'{64'd4, 1'b1, 1'b0},                      // even
		'{64'd3, 1'b0, 1'b0},
		'{64'd7, 1'b0, 1'b0},                      // witness 7 vanishes mod n
		'{64'd61, 1'b0, 1'b0},                     // witness 61 vanishes mod n
		'{64'd11, 1'b0, 1'b0},
		'{64'd13, 1'b0, 1'b0},
		'{64'd9, 1'b0, 1'b0},
		'{64'd341, 1'b0, 1'b0},                    // base-2 pseudoprime
		'{64'd561, 1'b0, 1'b0},                    // Carmichael
		'{64'd2047, 1'b0, 1'b0},                   // base-2 strong pseudoprime
		'{64'd1000000007, 1'b0, 1'b0},
		'{64'd3215031751, 1'b0, 1'b0},             // fools bases 2,3,5,7
		'{64'd4759123140, 1'b1, 1'b0},             // three-witness limit, even
		'{64'd4759123141, 1'b0, 1'b0},             // first six-witness value
		'{64'd3474749660382, 1'b1, 1'b0},          // six-witness limit, even
		'{64'd3474749660383, 1'b0, 1'b0},          // first seven-witness value
		'{64'd18446744073709551557, 1'b0, 1'b0},   // largest 64-bit prime
		'{64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b0},    // top even
		'{64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0}     // all ones, divisible by 3
	};

	initial begin
		int unsigned wait_cycles;
		cycles = 0;
		errors = 0;
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i])
			send_number(probes[i].n, probes[i].pinned, probes[i].verdict);

		// hold off until the block has drained everything
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);

		// random phases: free run, idle sender, stalling receiver, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin snd_idle_pct = 86; rcv_stall_pct = 0;  end
				2: begin snd_idle_pct = 0;  rcv_stall_pct = 86; end
				default: begin snd_idle_pct = 27; rcv_stall_pct = 27; end
			endcase
			repeat (RAND_PER_PHASE)
				send_number(pick_number(), 1'b0, 1'b0);
		end
		s_axis_tvalid <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		wait_cycles = 0;
		while (wait_cycles < DRAIN_CYCLES) begin
			@(posedge clk);
			wait_cycles++;
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

>>> filelist.f
design/mrpt_pkg.sv
design/mrpt_mulmod.sv
design/miller_rabin_prime_test.sv
design/mrpt_checker.sv
verif/tb_miller_rabin_prime_test.sv
